### rtl/irad_pkg.sv
// ----------------------------------------------------------------------------
// irad_pkg
// Shared types and constants of the interleaved RTP audio decoder.
// ----------------------------------------------------------------------------
package irad_pkg;

  // Fixed RTP header length in bytes (no CSRC list, no extension)
  localparam int unsigned RtpHeaderBytes = 12;

  localparam int unsigned PosWidth = 17;
  localparam logic [PosWidth-1:0] PosMax = {PosWidth{1'b1}};

  // Frame position of the first payload byte: '$', channel, length, header
  localparam logic [PosWidth-1:0] PayloadFirstPos = PosWidth'(4 + RtpHeaderBytes);
  localparam logic [PosWidth-1:0] PtBytePos       = PosWidth'(5);

  localparam logic [7:0] FrameMarker = 8'h24;

  localparam logic [6:0] PtMulaw = 7'd0;
  localparam logic [6:0] PtAlaw  = 7'd8;

  localparam logic [6:0] L16PtReset = 7'd97;

  // Configuration register indexes
  localparam logic CfgAudioChannel  = 1'b0;
  localparam logic CfgL16PayloadType = 1'b1;

  typedef enum logic [1:0] {
    KindNone  = 2'd0,
    KindL16   = 2'd1,
    KindMulaw = 2'd2,
    KindAlaw  = 2'd3
  } decode_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_sample;
  } out_word_t;

endpackage

### rtl/irad_g711_dec.sv
// ----------------------------------------------------------------------------
// irad_g711_dec
// G.711 expander: mu-law or A-law code byte to 16-bit linear PCM.
// ----------------------------------------------------------------------------
module irad_g711_dec import irad_pkg::*; (
  input  logic [7:0]         code_i,
  input  logic               alaw_i,
  output logic signed [15:0] pcm_o
);

  logic [7:0]  mu_v;
  logic [15:0] mu_mag;
  logic [15:0] mu_pcm;
  logic [7:0]  a_v;
  logic [2:0]  a_seg;
  logic [15:0] a_mag;
  logic [15:0] a_pcm;

  // mu-law: complement, rebuild biased magnitude, then remove the bias
  always_comb begin
    mu_v   = ~code_i;
    mu_mag = (16'({mu_v[3:0], 3'b000}) + 16'h0084) << mu_v[6:4];
    mu_pcm = mu_v[7] ? (16'h0084 - mu_mag) : (mu_mag - 16'h0084);
  end

  // A-law: undo even-bit inversion; the lowest segment has no implied one
  always_comb begin
    a_v   = code_i ^ 8'h55;
    a_seg = a_v[6:4];
    if (a_seg == 3'd0) begin
      a_mag = 16'({a_v[3:0], 4'b0000}) + 16'h0008;
    end else begin
      a_mag = (16'({a_v[3:0], 4'b0000}) + 16'h0108) << (a_seg - 3'd1);
    end
    a_pcm = a_v[7] ? a_mag : (16'h0000 - a_mag);
  end

  assign pcm_o = alaw_i ? a_pcm : mu_pcm;

endmodule

### rtl/interleaved_rtp_audio_decoder_core.sv
// ----------------------------------------------------------------------------
// interleaved_rtp_audio_decoder_core
// Byte-serial decoder of TCP-interleaved RTP audio frames to 16-bit PCM.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one frame byte per word; frame_start marks the '$' byte.
//   out_*  : one PCM sample per word; last_sample flags the frame's final one.
//   cfg_*  : write-only registers (audio channel, L16 payload type); the user
//            must write them only while the block is idle (not enforced).
// Frames on another channel, shorter than the RTP header, or with an unknown
// payload type give no words. L16 pairs bytes big-endian; PCMU/PCMA bytes are
// expanded and each sample is sent twice.
// Latency: a result appears on out_* the cycle after its byte is accepted.
// Throughput: header and L16 bytes are taken every cycle while out_ready_i
// is high; a G.711 byte yields two words through the single output port, so
// the next byte waits for the pair to drain. A two-entry result buffer sets
// this: a byte is taken only when the buffer is or becomes empty that cycle.
// Reset: all frame state clears, no frame is active, the audio channel is 0
// and the L16 payload type is 97. When the receiver stalls, the buffer holds
// and in_ready_o drops until it drains; no word is lost.
// ----------------------------------------------------------------------------
module interleaved_rtp_audio_decoder_core import irad_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  // Configuration registers
  logic [7:0] audio_ch_q;
  logic [6:0] l16_pt_q;

  // Frame state
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [15:0]         flen_q, flen_d;
  logic                acc_q, acc_d;
  decode_kind_e        kind_q, kind_d;
  logic [7:0]          held_q, held_d;

  // Result buffer: slot0 faces the output port
  out_word_t  slot0_q, slot1_q;
  logic [1:0] cnt_q;

  logic in_fire, out_fire;
  logic [1:0] n_res;
  out_word_t  res0, res1;

  logic [7:0]          b;
  logic [PosWidth-1:0] idx;
  logic [PosWidth-1:0] frame_end;
  logic [PosWidth-1:0] p;
  logic [15:0]         plen;
  logic [6:0]          pt;
  logic signed [15:0]  g711_pcm;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_word_o  = slot0_q;
  assign out_fire    = out_valid_o && out_ready_i;
  // Take a byte only when the buffer is free by the end of this cycle
  assign in_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;

  assign b = in_word_i.data_byte;

  // The decode kind changes only on the '$' and payload type bytes, not on a
  // payload byte, so the stored kind selects the expander
  irad_g711_dec u_g711 (
    .code_i (b),
    .alaw_i (kind_q == KindAlaw),
    .pcm_o  (g711_pcm)
  );

  // Per-byte frame walk, mirrors one step of the frame parser
  always_comb begin
    pos_d  = pos_q;
    flen_d = flen_q;
    acc_d  = acc_q;
    kind_d = kind_q;
    held_d = held_q;
    n_res  = 2'd0;
    res0   = '{sample: g711_pcm, last_sample: 1'b0};
    res1   = '{sample: g711_pcm, last_sample: 1'b0};
    idx    = pos_q;
    pt     = b[6:0];
    if (in_word_i.frame_start) begin
      idx    = '0;
      flen_d = '0;
      kind_d = KindNone;
      held_d = '0;
    end
    frame_end = PosWidth'(3) + PosWidth'(flen_d);
    p         = idx - PayloadFirstPos;
    plen      = flen_d - 16'(RtpHeaderBytes);
    // Drop stray bytes outside any frame
    if (in_word_i.frame_start || (pos_q != '0)) begin
      pos_d = (idx != PosMax) ? idx + PosWidth'(1) : idx;
      case (idx)
        PosWidth'(0): acc_d = (b == FrameMarker);
        PosWidth'(1): acc_d = acc_q && (b == audio_ch_q);
        PosWidth'(2): flen_d = {b, 8'h00};
        PosWidth'(3): begin
          flen_d = {flen_d[15:8], b};
          if ({flen_d[15:8], b} < 16'(RtpHeaderBytes)) begin
            acc_d = 1'b0;
          end
        end
        default: begin
          if (acc_q && (idx <= frame_end)) begin
            if (idx == PtBytePos) begin
              if (pt == l16_pt_q) begin
                kind_d = KindL16;
              end else if (pt == PtMulaw) begin
                kind_d = KindMulaw;
              end else if (pt == PtAlaw) begin
                kind_d = KindAlaw;
              end else begin
                kind_d = KindNone;
                acc_d  = 1'b0;
              end
            end
            if (acc_d && (idx >= PayloadFirstPos)) begin
              case (kind_d)
                KindL16: begin
                  if (!p[0]) begin
                    held_d = b;
                  end else begin
                    res0.sample      = {held_d, b};
                    res0.last_sample = ({1'b0, p} + 18'd2) >= 18'(plen);
                    n_res            = 2'd1;
                  end
                end
                KindMulaw, KindAlaw: begin
                  res1.last_sample = ({1'b0, p} + 18'd1) == 18'(plen);
                  n_res            = 2'd2;
                end
                default: n_res = 2'd0;
              endcase
            end
          end
        end
      endcase
      // Close the frame once its length is used up
      if ((idx >= PosWidth'(4)) && (idx >= frame_end)) begin
        acc_d = 1'b0;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_ch_q <= '0;
      l16_pt_q   <= L16PtReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgAudioChannel:   audio_ch_q <= cfg_data_i;
        CfgL16PayloadType: l16_pt_q   <= cfg_data_i[6:0];
        default:           audio_ch_q <= audio_ch_q;
      endcase
    end
  end

  // Frame state: advance on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      flen_q <= '0;
      acc_q  <= 1'b0;
      kind_q <= KindNone;
      held_q <= '0;
    end else if (in_fire) begin
      pos_q  <= pos_d;
      flen_q <= flen_d;
      acc_q  <= acc_d;
      kind_q <= kind_d;
      held_q <= held_d;
    end
  end

  // Result buffer: load a fresh result set, or shift one out per pop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (in_fire && (n_res != 2'd0)) begin
      cnt_q <= n_res;
    end else if (out_fire) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (n_res != 2'd0)) begin
      slot0_q <= res0;
      slot1_q <= res1;
    end else if (out_fire) begin
      slot0_q <= slot1_q;
    end
  end

  // A byte is taken only into an empty or draining buffer
  a_in_buffer_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> ((cnt_q == 2'd0) || out_fire))
    else $error("byte accepted while results still pending");

  // A G.711 byte leaves exactly two words queued
  a_g711_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (n_res == 2'd2)) |=> (cnt_q == 2'd2))
    else $error("G.711 byte did not queue two samples");

  // The first copy of an upsampled pair never carries the frame-end flag
  a_first_copy_unflagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !slot0_q.last_sample)
    else $error("first sample of a pair flagged as last");

endmodule
